@@ src/ptp_pkg.sv @@
// Shared constants, codes and types for the priority table with promote.
// No dependencies; ptp_scan and the top-level module refer to this package by scoped name.

package ptp_pkg;

   // Default sizing handed to the top-level parameters
   localparam int CAPACITY_DEFAULT      = 64;
   localparam int ELEMENT_BITS_DEFAULT  = 32;
   localparam int PRIORITY_BITS_DEFAULT = 16;

   // Fixed field widths of the request and response ports
   localparam int ID_BITS     = 6;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_ADD     = 2'd0;
   localparam logic [OP_BITS-1:0] OP_PROMOTE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_POP     = 2'd2;
   localparam logic [OP_BITS-1:0] OP_QUERY   = 2'd3;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd3;

   // Status of the maximum scan unit towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } scan_status_type;

endpackage

@@ src/ptp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module ptp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ptp_scan.sv @@
// Maximum scan unit: walks the priority RAM over all issued ids, one read a cycle.
// Depends on ptp_pkg; the caller owns the RAM and routes scan_addr to its read port.

module ptp_scan #(
   parameter int CAPACITY      = ptp_pkg::CAPACITY_DEFAULT,
   parameter int PRIORITY_BITS = ptp_pkg::PRIORITY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             scan_start,
   input  logic [$clog2(CAPACITY+1)-1:0]    entry_count,
   input  logic [PRIORITY_BITS:0]           prio_rd_data,
   output logic [$clog2(CAPACITY)-1:0]      scan_addr,
   output logic [$clog2(CAPACITY)-1:0]      best_id,
   output logic [PRIORITY_BITS-1:0]         best_prio,
   output ptp_pkg::scan_status_type         scan_stat
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic                     active_ff, active_in;
   logic [CNT_W-1:0]         addr_ff, addr_in;
   logic                     pend_ff, pend_in;
   logic [ADDR_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                     found_ff, found_in;
   logic [ADDR_W-1:0]        best_id_ff, best_id_in;
   logic [PRIORITY_BITS-1:0] best_prio_ff, best_prio_in;
   logic                     issue;
   logic                     done;
   logic                     rd_live;
   logic [PRIORITY_BITS-1:0] rd_prio;

   assign rd_live = prio_rd_data[PRIORITY_BITS];
   assign rd_prio = prio_rd_data[PRIORITY_BITS-1:0];
   assign issue   = active_ff && (addr_ff < entry_count);
   assign done    = active_ff && !issue && !pend_ff;

   // Issue one read a cycle, compare the data returned for the previous id
   always_comb begin
      active_in    = active_ff;
      addr_in      = addr_ff;
      pend_in      = issue;
      pend_idx_in  = addr_ff[ADDR_W-1:0];
      found_in     = found_ff;
      best_id_in   = best_id_ff;
      best_prio_in = best_prio_ff;
      if (issue) begin
         addr_in = addr_ff + CNT_W'(1);
      end
      // Ties go to the later id, as the walk runs upwards
      if (pend_ff && rd_live && (!found_ff || rd_prio >= best_prio_ff)) begin
         found_in     = 1'b1;
         best_id_in   = pend_idx_ff;
         best_prio_in = rd_prio;
      end
      if (done) begin
         active_in = 1'b0;
      end
      if (scan_start) begin
         active_in = 1'b1;
         addr_in   = '0;
         pend_in   = 1'b0;
         found_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
      end
      addr_ff      <= addr_in;
      pend_idx_ff  <= pend_idx_in;
      best_id_ff   <= best_id_in;
      best_prio_ff <= best_prio_in;
   end

   assign scan_addr       = addr_ff[ADDR_W-1:0];
   assign best_id         = best_id_ff;
   assign best_prio       = best_prio_ff;
   assign scan_stat.busy  = active_ff;
   assign scan_stat.done  = done;
   assign scan_stat.found = found_ff;

   // The walk never runs past the issued ids
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> addr_ff <= entry_count)
      else $error("scan address ran past the entry count");

endmodule

@@ src/priority_table_with_promote_top.sv @@
// Priority table with promote: one request at a time.
// The response waits on a walk of the priority RAM over all issued ids; promote or query of
// an issued id reads its entry first, and the element fetch is skipped when nothing is live.
// A new request is taken in the cycle after the response is loaded, even while it waits.
// Reset clears the id count, the sequencer and the response valid; RAM contents stay.
// Depends on ptp_pkg, ptp_ram and ptp_scan.

module priority_table_with_promote_top #(
   parameter int CAPACITY      = ptp_pkg::CAPACITY_DEFAULT,
   parameter int ELEMENT_BITS  = ptp_pkg::ELEMENT_BITS_DEFAULT,
   parameter int PRIORITY_BITS = ptp_pkg::PRIORITY_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ptp_pkg::OP_BITS-1:0]     req_operation,
   input  logic [ptp_pkg::ID_BITS-1:0]     req_entry_id,
   input  logic [ELEMENT_BITS-1:0]         req_element_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ptp_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [ptp_pkg::ID_BITS-1:0]     rsp_assigned_id,
   output logic                            rsp_id_live,
   output logic [ELEMENT_BITS-1:0]         rsp_id_element,
   output logic                            rsp_max_present,
   output logic [ptp_pkg::ID_BITS-1:0]     rsp_max_id,
   output logic [ELEMENT_BITS-1:0]         rsp_max_element,
   output logic [PRIORITY_BITS-1:0]        rsp_max_priority
);

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ID_W    = ptp_pkg::ID_BITS;
   localparam int PW      = PRIORITY_BITS + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_FETCH = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                        state_ff, state_in;
   logic [ptp_pkg::OP_BITS-1:0]       op_ff, op_in;
   logic [ID_W-1:0]                   id_ff, id_in;
   logic [ELEMENT_BITS-1:0]           elem_ff, elem_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [ptp_pkg::STATUS_BITS-1:0]   status_ff, status_in;
   logic [ID_W-1:0]                   assigned_ff, assigned_in;
   logic                              qlive_ff, qlive_in;
   logic [ELEMENT_BITS-1:0]           qelem_ff, qelem_in;
   logic [ELEMENT_BITS-1:0]           melem_ff, melem_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ptp_pkg::STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]                   rsp_assigned_ff, rsp_assigned_in;
   logic                              rsp_live_ff, rsp_live_in;
   logic [ELEMENT_BITS-1:0]           rsp_qelem_ff, rsp_qelem_in;
   logic                              rsp_mpres_ff, rsp_mpres_in;
   logic [ID_W-1:0]                   rsp_mid_ff, rsp_mid_in;
   logic [ELEMENT_BITS-1:0]           rsp_melem_ff, rsp_melem_in;
   logic [PRIORITY_BITS-1:0]          rsp_mprio_ff, rsp_mprio_in;

   logic                              elem_we;
   logic [ADDR_W-1:0]                 elem_ra;
   logic [ELEMENT_BITS-1:0]           elem_rd;
   logic                              prio_we;
   logic [ADDR_W-1:0]                 prio_wa;
   logic [PW-1:0]                     prio_wd;
   logic [ADDR_W-1:0]                 prio_ra;
   logic [PW-1:0]                     prio_rd;

   logic                              scan_start;
   logic [ADDR_W-1:0]                 scan_addr;
   logic [ADDR_W-1:0]                 best_id;
   logic [PRIORITY_BITS-1:0]          best_prio;
   ptp_pkg::scan_status_type          scan_stat;

   logic [CNT_W+ID_W-1:0]             id_wide;
   logic [CNT_W+ID_W-1:0]             cnt_wide;
   logic [ADDR_W+ID_W-1:0]            id_ext;
   logic [ADDR_W+ID_W-1:0]            best_ext;
   logic [ADDR_W-1:0]                 id_addr;
   logic [ID_W-1:0]                   best_id6;
   logic                              id_valid;
   logic                              table_full;
   logic                              rsp_free;
   logic [PRIORITY_BITS-1:0]          prio_cur;
   logic [PRIORITY_BITS-1:0]          prio_inc;

   // Widen ids and the count to a common width before comparing
   assign id_wide    = {{CNT_W{1'b0}}, id_ff};
   assign cnt_wide   = {{ID_W{1'b0}}, count_ff};
   assign id_ext     = {{ADDR_W{1'b0}}, id_ff};
   assign best_ext   = {{ID_W{1'b0}}, best_id};
   assign id_addr    = id_ext[ADDR_W-1:0];
   assign best_id6   = best_ext[ID_W-1:0];
   assign id_valid   = id_wide < cnt_wide;
   assign table_full = count_ff == CNT_W'(CAPACITY);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Saturating increment of the stored priority
   assign prio_cur = prio_rd[PRIORITY_BITS-1:0];
   assign prio_inc = (prio_cur == {PRIORITY_BITS{1'b1}}) ? prio_cur
                                                          : prio_cur + PRIORITY_BITS'(1);

   // Route RAM read addresses by phase
   assign elem_ra = (state_ff == S_SCAN) ? best_id : id_addr;
   assign prio_ra = (state_ff == S_EXEC) ? id_addr : scan_addr;

   // Sequencer: execute, read the entry if needed, walk for the maximum, fetch, respond
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      id_in           = id_ff;
      elem_in         = elem_ff;
      count_in        = count_ff;
      status_in       = status_ff;
      assigned_in     = assigned_ff;
      qlive_in        = qlive_ff;
      qelem_in        = qelem_ff;
      melem_in        = melem_ff;
      elem_we         = 1'b0;
      prio_we         = 1'b0;
      prio_wa         = count_ff[ADDR_W-1:0];
      prio_wd         = {1'b1, {PRIORITY_BITS{1'b0}}};
      scan_start      = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_assigned_in = rsp_assigned_ff;
      rsp_live_in     = rsp_live_ff;
      rsp_qelem_in    = rsp_qelem_ff;
      rsp_mpres_in    = rsp_mpres_ff;
      rsp_mid_in      = rsp_mid_ff;
      rsp_melem_in    = rsp_melem_ff;
      rsp_mprio_in    = rsp_mprio_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               id_in    = req_entry_id;
               elem_in  = req_element_in;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in   = ptp_pkg::STATUS_OK;
            assigned_in = '0;
            qlive_in    = 1'b0;
            qelem_in    = '0;
            unique case (op_ff)
               ptp_pkg::OP_ADD: begin
                  if (table_full) begin
                     status_in = ptp_pkg::STATUS_FULL;
                  end else begin
                     elem_we     = 1'b1;
                     prio_we     = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                     assigned_in = cnt_wide[ID_W-1:0];
                  end
                  scan_start = 1'b1;
                  state_in   = S_SCAN;
               end
               ptp_pkg::OP_POP: begin
                  scan_start = 1'b1;
                  state_in   = S_SCAN;
               end
               default: begin
                  // Promote and query read the entry first
                  if (id_valid) begin
                     state_in = S_CHECK;
                  end else begin
                     status_in  = ptp_pkg::STATUS_INVALID;
                     scan_start = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
            endcase
         end
         S_CHECK: begin
            if (op_ff == ptp_pkg::OP_PROMOTE) begin
               if (prio_rd[PRIORITY_BITS]) begin
                  prio_we = 1'b1;
                  prio_wa = id_addr;
                  prio_wd = {1'b1, prio_inc};
               end else begin
                  status_in = ptp_pkg::STATUS_INVALID;
               end
            end else begin
               qlive_in = prio_rd[PRIORITY_BITS];
               qelem_in = elem_rd;
            end
            scan_start = 1'b1;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (scan_stat.done) begin
               if (scan_stat.found) begin
                  state_in = S_FETCH;
               end else begin
                  if (op_ff == ptp_pkg::OP_POP) begin
                     status_in = ptp_pkg::STATUS_EMPTY;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_FETCH: begin
            melem_in = elem_rd;
            // Pop drops the live mark, keeps the priority
            if (op_ff == ptp_pkg::OP_POP) begin
               prio_we = 1'b1;
               prio_wa = best_id;
               prio_wd = {1'b0, best_prio};
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_assigned_in = assigned_ff;
               rsp_live_in     = qlive_ff;
               rsp_qelem_in    = qelem_ff;
               rsp_mpres_in    = scan_stat.found;
               rsp_mid_in      = scan_stat.found ? best_id6 : '0;
               rsp_melem_in    = scan_stat.found ? melem_ff : '0;
               rsp_mprio_in    = scan_stat.found ? best_prio : '0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      id_ff           <= id_in;
      elem_ff         <= elem_in;
      status_ff       <= status_in;
      assigned_ff     <= assigned_in;
      qlive_ff        <= qlive_in;
      qelem_ff        <= qelem_in;
      melem_ff        <= melem_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_assigned_ff <= rsp_assigned_in;
      rsp_live_ff     <= rsp_live_in;
      rsp_qelem_ff    <= rsp_qelem_in;
      rsp_mpres_ff    <= rsp_mpres_in;
      rsp_mid_ff      <= rsp_mid_in;
      rsp_melem_ff    <= rsp_melem_in;
      rsp_mprio_ff    <= rsp_mprio_in;
   end

   // Element words
   ptp_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (CAPACITY)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (elem_ff),
      .rd_addr (elem_ra),
      .rd_data (elem_rd)
   );

   // Live mark on top of the priority
   ptp_ram #(
      .WIDTH (PW),
      .DEPTH (CAPACITY)
   ) u_prio_ram (
      .clock   (clock),
      .wr_en   (prio_we),
      .wr_addr (prio_wa),
      .wr_data (prio_wd),
      .rd_addr (prio_ra),
      .rd_data (prio_rd)
   );

   ptp_scan #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .scan_start   (scan_start),
      .entry_count  (count_ff),
      .prio_rd_data (prio_rd),
      .scan_addr    (scan_addr),
      .best_id      (best_id),
      .best_prio    (best_prio),
      .scan_stat    (scan_stat)
   );

   assign req_ready        = state_ff == S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_assigned_id  = rsp_assigned_ff;
   assign rsp_id_live      = rsp_live_ff;
   assign rsp_id_element   = rsp_qelem_ff;
   assign rsp_max_present  = rsp_mpres_ff;
   assign rsp_max_id       = rsp_mid_ff;
   assign rsp_max_element  = rsp_melem_ff;
   assign rsp_max_priority = rsp_mprio_ff;

   // The id count never passes the table size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("id count exceeds capacity");

   // No priority write while the walk reads the RAM
   assert property (@(posedge clock) disable iff (reset)
      !(prio_we && scan_stat.busy))
      else $error("priority write during maximum scan");

   // The walk only completes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      scan_stat.done |-> state_ff == S_SCAN)
      else $error("scan completed outside the scan phase");

   // An empty pop never reports a maximum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ptp_pkg::STATUS_EMPTY) |-> !rsp_mpres_ff)
      else $error("empty pop reports a maximum");

endmodule
